@@ sv/pds_pkg.sv @@
// ============================================================================
// pds_pkg: shared types and constants of the 2x2 pixel downscaler
// Channel widths, config register indexes, pair-sum and stage types.
// ============================================================================
`timescale 1ns / 1ps

package pds_pkg;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int HEIGHT_LIMIT  = 4096;

	localparam int CH_W       = 8;   // one color channel
	localparam int SUM_W      = 9;   // horizontal pair sum of one channel
	localparam int TOT_W      = 10;  // full 2x2 block sum of one channel
	localparam int ROW_W      = 12;  // row counter
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} pair_t;

	// what the front end hands to the summing stage for one accepted pixel
	typedef struct packed {
		logic  emit;       // this pixel completes a block
		logic  use_above;  // add the line buffer entry (second row of a pair)
		logic  row_end;
		logic  frame_end;
		pair_t pair;
	} stage_t;

endpackage

@@ sv/pds_pix_if.sv @@
// ============================================================================
// pds_pix_if: input pixel channel
// Valid/ready channel carrying one RGB pixel per word.
// ============================================================================
`timescale 1ns / 1ps

interface pds_pix_if import pds_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] pixel_red;
	logic [CH_W-1:0] pixel_green;
	logic [CH_W-1:0] pixel_blue;

	modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
		input ready);
	modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
		output ready);
endinterface

@@ sv/pds_res_if.sv @@
// ============================================================================
// pds_res_if: output pixel channel
// Valid/ready channel carrying one downscaled pixel and its end flags per word.
// ============================================================================
`timescale 1ns / 1ps

interface pds_res_if import pds_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            row_end;
	logic            frame_end;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output row_end, output frame_end, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input row_end, input frame_end, output ready);
endinterface

@@ sv/pds_cfg_if.sv @@
// ============================================================================
// pds_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per word.
// ============================================================================
`timescale 1ns / 1ps

interface pds_cfg_if import pds_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/pixel_downscale_2x2_top.sv @@
// ============================================================================
// pixel_downscale_2x2_top: 2x2 box-filter downscaler for raster RGB pixels
// Path: a block's last pixel passes the stage 1 register, then the output
//   register, before it shows as a result word.
// Throughput: one pixel per cycle unless the output stalls; the line buffer
//   takes at most one write or one read per pixel; nothing in the path repeats.
// Reset: arst_n clears counters, left pixel hold and valid flags; width goes
//   to min(MAX_WIDTH, 4096), height to 4096. Line buffer keeps its contents.
// ============================================================================
`timescale 1ns / 1ps

module pixel_downscale_2x2_top import pds_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	pds_pix_if.sink   pix,
	pds_res_if.source res,
	pds_cfg_if.sink   cfg
);

	// Line buffer holds one pair sum per column pair; an odd width gets
	// one extra entry for its lone last column.
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic          take;
	logic          s1_ready;
	rgb_t          px;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	pair_t         mem_wdata;
	pair_t         mem_rdata;
	stage_t        stage;
	rgb_t          res_rgb;

	// Config words are taken at any time; the frame restarts on each one.
	assign cfg.ready = 1'b1;

	// Input word goes straight into the sum stage; ready only depends on
	// whether that stage can move on.
	assign pix.ready = s1_ready;
	assign take      = pix.valid && s1_ready;

	assign px.red   = pix.pixel_red;
	assign px.green = pix.pixel_green;
	assign px.blue  = pix.pixel_blue;

	// Stage 0: counters, pair sums, line buffer write (first row of a pair)
	// or read (second row of a pair).
	pds_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.px        (px),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.stage     (stage)
	);

	// A row pair's second row reads an entry in a later cycle than the first row
	// wrote it, so write-then-read needs no forwarding.
	pds_line_mem #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Stage 1 and output register: block sum, divide by four, hold the word.
	pds_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.stage         (stage),
		.above         (mem_rdata),
		.res_ready     (res.ready),
		.s1_ready      (s1_ready),
		.res_valid     (res.valid),
		.res_rgb       (res_rgb),
		.res_row_end   (res.row_end),
		.res_frame_end (res.frame_end)
	);

	assign res.out_red   = res_rgb.red;
	assign res.out_green = res_rgb.green;
	assign res.out_blue  = res_rgb.blue;

endmodule

@@ sv/pds_line_mem.sv @@
// ============================================================================
// pds_line_mem: pair-sum line buffer
// One write and one read per cycle at a shared address, registered read data.
// ============================================================================
`timescale 1ns / 1ps

module pds_line_mem import pds_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH / 2,
	parameter int AW    = $clog2(DEF_MAX_WIDTH / 2)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  pair_t         wdata,
	output pair_t         rdata
);

	pair_t mem [DEPTH];
	pair_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/pds_ctrl.sv @@
// ============================================================================
// pds_ctrl: front end of the downscaler
// Config registers, column/row counters, left pixel hold, pair sums, line
// buffer access and per-pixel stage word.
// ============================================================================
`timescale 1ns / 1ps

module pds_ctrl import pds_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int CW        = $clog2(DEF_MAX_WIDTH),
	parameter int AW        = $clog2(DEF_MAX_WIDTH / 2)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  rgb_t                  px,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  mem_we,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_addr,
	output pair_t                 mem_wdata,
	output stage_t                stage
);

	localparam int EW      = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
	localparam int W_RESET = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

	logic [CW-1:0]    wlast_q;
	logic [ROW_W-1:0] hlast_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	rgb_t             left_q;

	logic [EW-1:0]    wr_x;
	logic [CW-1:0]    wlast_new;
	logic [ROW_W-1:0] hlast_new;
	logic [CW-1:0]    col_half;
	logic             last_col;
	logic             last_row;
	logic             have_pair;
	rgb_t             left;
	pair_t            pair;

	// effective last column / last row of a written value, clamped to range
	always_comb begin
		wr_x = EW'(cfg_data);
		if (wr_x == '0) begin
			wlast_new = '0;
		end else if (wr_x > EW'(MAX_WIDTH)) begin
			wlast_new = CW'(MAX_WIDTH - 1);
		end else begin
			wlast_new = CW'(wr_x - EW'(1));
		end
		if (cfg_data == '0) begin
			hlast_new = '0;
		end else if (cfg_data > CFG_DATA_W'(HEIGHT_LIMIT)) begin
			hlast_new = ROW_W'(HEIGHT_LIMIT - 1);
		end else begin
			hlast_new = ROW_W'(cfg_data - CFG_DATA_W'(1));
		end
	end

	assign last_col  = (col_q == wlast_q);
	assign last_row  = (row_q == hlast_q);
	assign have_pair = col_q[0] || last_col;
	assign left      = col_q[0] ? left_q : '0;
	assign col_half  = col_q >> 1;

	always_comb begin
		pair.red   = SUM_W'(px.red) + SUM_W'(left.red);
		pair.green = SUM_W'(px.green) + SUM_W'(left.green);
		pair.blue  = SUM_W'(px.blue) + SUM_W'(left.blue);
	end

	// even row: store the pair, unless it is the lone last row
	// odd row: fetch the pair stored above
	assign mem_we    = take && have_pair && !row_q[0] && !last_row;
	assign mem_re    = take && have_pair && row_q[0];
	assign mem_addr  = col_half[AW-1:0];
	assign mem_wdata = pair;

	always_comb begin
		stage.emit      = have_pair && (row_q[0] || last_row);
		stage.use_above = row_q[0];
		stage.row_end   = last_col;
		stage.frame_end = last_col && last_row;
		stage.pair      = pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CW'(W_RESET - 1);
			hlast_q <= ROW_W'(HEIGHT_LIMIT - 1);
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
		end else if (cfg_we) begin
			// any write restarts the frame
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  wlast_q <= wlast_new;
				REG_IMAGE_HEIGHT: hlast_q <= hlast_new;
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (take) begin
			if (!have_pair) begin
				left_q <= px;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

@@ sv/pds_out.sv @@
// ============================================================================
// pds_out: block sum stage and output register
// Adds the line buffer entry, divides by four, holds the result word.
// ============================================================================
`timescale 1ns / 1ps

module pds_out import pds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  stage_t stage,
	input  pair_t  above,
	input  logic   res_ready,
	output logic   s1_ready,
	output logic   res_valid,
	output rgb_t   res_rgb,
	output logic   res_row_end,
	output logic   res_frame_end
);

	logic   valid_s1;
	stage_t data_s1;
	logic   out_valid_q;
	rgb_t   rgb_q;
	logic   row_end_q;
	logic   frame_end_q;

	logic   out_free;
	pair_t  add;
	logic [TOT_W-1:0] tot_r, tot_g, tot_b;

	assign out_free = !out_valid_q || res_ready;
	assign s1_ready = !valid_s1 || out_free;

	assign add   = data_s1.use_above ? above : '0;
	assign tot_r = TOT_W'(data_s1.pair.red) + TOT_W'(add.red);
	assign tot_g = TOT_W'(data_s1.pair.green) + TOT_W'(add.green);
	assign tot_b = TOT_W'(data_s1.pair.blue) + TOT_W'(add.blue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= take && stage.emit;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && take) begin
			data_s1 <= stage;
		end
		if (out_free && valid_s1) begin
			rgb_q.red   <= tot_r[TOT_W-1:2];
			rgb_q.green <= tot_g[TOT_W-1:2];
			rgb_q.blue  <= tot_b[TOT_W-1:2];
			row_end_q   <= data_s1.row_end;
			frame_end_q <= data_s1.frame_end;
		end
	end

	assign res_valid     = out_valid_q;
	assign res_rgb       = rgb_q;
	assign res_row_end   = row_end_q;
	assign res_frame_end = frame_end_q;

endmodule

@@ sv/pds_checker.sv @@
// ============================================================================
// pds_checker: port-level checks of the downscaler
// Result word ordering, stall hold and flow through the two-stage path.
// ============================================================================
`timescale 1ns / 1ps

module pds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_red,
	input logic [7:0] res_green,
	input logic [7:0] res_blue,
	input logic       res_row_end,
	input logic       res_frame_end
);

	// last pixel of the frame is also last of its row
	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_frame_end |-> res_row_end)
		else $error("frame_end without row_end");

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_red) && $stable(res_green)
			&& $stable(res_blue) && $stable(res_row_end) && $stable(res_frame_end))
		else $error("result word changed under stall");

	// a fresh result traces back to an accepted input pixel
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
		else $error("result word without matching input");

	// empty output means the input side is open
	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input blocked with empty output");

endmodule

bind pixel_downscale_2x2_top pds_checker u_pds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_red       (res.out_red),
	.res_green     (res.out_green),
	.res_blue      (res.out_blue),
	.res_row_end   (res.row_end),
	.res_frame_end (res.frame_end)
);
